@@ rtl/core/sldf_pkg.sv @@
// Shared types and constants for the sync/length/checksum frame deframer.
`default_nettype none
package sldf_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_LENGTH      = 2'd2,
    PH_BODY        = 2'd3
  } sldf_phase_t;

  typedef enum logic [1:0] {
    RP_IDLE = 2'd0,
    RP_READ = 2'd1,
    RP_HOLD = 2'd2
  } sldf_replay_t;

  // Parser to replay unit: body store write and replay start.
  typedef struct packed {
    logic              wr_en;
    logic [LEN_W-1:0]  wr_pos;
    logic [BYTE_W-1:0] wr_data;
    logic              start;
    logic [LEN_W-1:0]  len;
  } sldf_req_t;

endpackage
`default_nettype wire

@@ rtl/core/sldf_parser.sv @@
// Byte parser: sync hunt, length check, body sum and checksum compare.
`default_nettype none
module sldf_parser #(
  parameter int MAX_BODY_LEN = 60
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sldf_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                           byte_valid,
  input  wire logic [sldf_pkg::BYTE_W-1:0]    byte_data,
  output sldf_pkg::sldf_req_t                 req
);
  import sldf_pkg::*;

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_BODY_LEN);

  sldf_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0] sync_first_r, sync_second_r;
  logic [LEN_W-1:0]  declared_len_r, declared_len_nxt;
  logic [LEN_W-1:0]  recv_cnt_r, recv_cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              body_more;

  assign body_more = recv_cnt_r < declared_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    declared_len_nxt = declared_len_r;
    recv_cnt_nxt     = recv_cnt_r;
    sum_nxt          = sum_r;
    if (byte_valid) begin
      case (phase_r)
        PH_HUNT_FIRST: begin
          if (byte_data == sync_first_r) phase_nxt = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          // The second sync byte wins when both registers hold the same value.
          if (byte_data == sync_second_r)     phase_nxt = PH_LENGTH;
          else if (byte_data == sync_first_r) phase_nxt = PH_HUNT_SECOND;
          else                                phase_nxt = PH_HUNT_FIRST;
        end
        PH_LENGTH: begin
          if (byte_data > MAX_LEN) begin
            phase_nxt = PH_HUNT_FIRST;
          end else begin
            declared_len_nxt = byte_data[LEN_W-1:0];
            recv_cnt_nxt     = '0;
            sum_nxt          = '0;
            phase_nxt        = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_more) begin
            sum_nxt      = sum_r + byte_data;
            recv_cnt_nxt = recv_cnt_r + LEN_W'(1);
          end else begin
            phase_nxt = PH_HUNT_FIRST;
          end
        end
        default: phase_nxt = PH_HUNT_FIRST;
      endcase
    end
  end

  always_comb begin
    req.wr_en   = byte_valid && (phase_r == PH_BODY) && body_more;
    req.wr_pos  = recv_cnt_r;
    req.wr_data = byte_data;
    req.start   = byte_valid && (phase_r == PH_BODY) && !body_more &&
                  (declared_len_r != '0) && (byte_data == sum_r);
    req.len     = declared_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT_FIRST;
      declared_len_r <= '0;
      recv_cnt_r     <= '0;
      sum_r          <= '0;
    end else begin
      phase_r        <= phase_nxt;
      declared_len_r <= declared_len_nxt;
      recv_cnt_r     <= recv_cnt_nxt;
      sum_r          <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sldf_replay.sv @@
// Body store memory and the replay sequencer that reads it out after a good checksum.
`default_nettype none
module sldf_replay #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sldf_pkg::sldf_req_t         req,
  output logic                             busy,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic [sldf_pkg::BYTE_W-1:0]      res_byte,
  output logic [sldf_pkg::LEN_W-1:0]       res_index,
  output logic                             res_last
);
  import sldf_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [LEN_W:0] DEPTH_LIM = (LEN_W+1)'(STORE_DEPTH);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];

  sldf_replay_t      state_r, state_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic              wr_ok, rd_ok, is_last;

  assign wr_ok   = {1'b0, req.wr_pos} < DEPTH_LIM;
  assign rd_ok   = {1'b0, idx_r} < DEPTH_LIM;
  assign is_last = (idx_r + LEN_W'(1)) == len_r;

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_ok) mem[req.wr_pos[AW-1:0]] <= req.wr_data;
  end

  // Read data registers only load in the read cycle, so they hold while a result stalls.
  always_ff @(posedge clk) begin
    if (state_r == RP_READ) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
      rd_ok_r   <= rd_ok;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    case (state_r)
      RP_IDLE: begin
        if (req.start) begin
          state_nxt = RP_READ;
          idx_nxt   = '0;
          len_nxt   = req.len;
        end
      end
      RP_READ: state_nxt = RP_HOLD;
      RP_HOLD: begin
        if (res_ready) begin
          if (is_last) begin
            state_nxt = RP_IDLE;
          end else begin
            state_nxt = RP_READ;
            idx_nxt   = idx_r + LEN_W'(1);
          end
        end
      end
      default: state_nxt = RP_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != RP_IDLE);
    res_valid = (state_r == RP_HOLD);
    res_byte  = rd_ok_r ? rd_data_r : '0;
    res_index = idx_r;
    res_last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RP_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sync_length_sum_frame_deframer.sv @@
// Top level of the sync/length/checksum frame deframer.
// Input: one byte per cycle while no frame is being replayed; a frame of N body bytes
// takes N + 4 input requests (two sync, length, body, checksum).
// Replay: each body byte is read from the body store into a register in the read state,
// then offered in the hold state until taken; input is held off during replay.
// Reset (rst_n, synchronous, active low) returns to sync hunt and restores the sync bytes.
`default_nettype none
module sync_length_sum_frame_deframer #(
  parameter int MAX_BODY_LEN = 60,
  parameter int STORE_DEPTH  = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sldf_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [15:0]                         out_tdata,  // [7:0] body_byte, [13:8] body_index
  output logic                                out_tlast
);
  import sldf_pkg::*;

  sldf_req_t         req;
  logic              busy;
  logic [BYTE_W-1:0] res_byte;
  logic [LEN_W-1:0]  res_index;

  assign in_tready = !busy;

  sldf_parser #(
    .MAX_BODY_LEN(MAX_BODY_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_valid(in_tvalid && in_tready),
    .byte_data (in_tdata),
    .req       (req)
  );

  sldf_replay #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_replay (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .busy     (busy),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_byte (res_byte),
    .res_index(res_index),
    .res_last (out_tlast)
  );

  assign out_tdata = {2'b00, res_index, res_byte};

endmodule
`default_nettype wire

@@ rtl/core/sldf_checker.sv @@
// Port-level assertions for the frame deframer, bound to the top level.
`default_nettype none
module sldf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // Input is held off while a result is offered.
  a_no_input_during_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is offered");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Every result is followed by a memory read cycle or by the return to idle.
  a_gap_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("result offered right after an accepted one");

  a_replay_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready ##1
      (out_tvalid && out_tdata[13:8] == $past(out_tdata[13:8], 2) + 6'd1))
    else $error("replay did not continue with the next body position");

  a_first_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && $past(in_tready, 2) |-> out_tdata[13:8] == 6'd0)
    else $error("frame replay did not start at body position zero");

endmodule

bind sync_length_sum_frame_deframer sldf_checker u_sldf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
`default_nettype wire

@@ tb/sldf_frame_checker.sv @@
// Watches the deframer's byte and body channels, predicts each verified body and checks it.
`timescale 1ns / 1ps
module sldf_frame_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sldf_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [15:0]                    out_tdata,  // [7:0] body_byte, [13:8] body_index
  input  wire logic                           out_tlast,
  output int                                  errors,
  output int                                  pending
);
  import sldf_pkg::*;

  localparam int LONGEST_BODY = 60;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [LEN_W-1:0]  body_index;
    logic              is_last;
  } body_beat_t;

  body_beat_t        body_q[$];
  logic [BYTE_W-1:0] first_sync;
  logic [BYTE_W-1:0] second_sync;
  sldf_phase_t       phase;
  logic [LEN_W-1:0]  body_len;
  logic [LEN_W-1:0]  body_seen;
  logic [BYTE_W-1:0] body_sum;
  logic [BYTE_W-1:0] body_mem [64];

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Advances the parser by one received byte and queues the replay of a verified body.
  task automatic take_byte(input logic [BYTE_W-1:0] b);
    int i;
    case (phase)
      PH_HUNT_FIRST: begin
        if (b == first_sync) phase = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        // The second sync byte is tested first, so it wins when both registers match.
        if (b == second_sync) phase = PH_LENGTH;
        else if (b == first_sync) phase = PH_HUNT_SECOND;
        else phase = PH_HUNT_FIRST;
      end
      PH_LENGTH: begin
        if (b > LONGEST_BODY) begin
          phase = PH_HUNT_FIRST;
        end else begin
          body_len  = b[LEN_W-1:0];
          body_seen = '0;
          body_sum  = '0;
          phase     = PH_BODY;
        end
      end
      default: begin
        if (body_seen < body_len) begin
          body_mem[body_seen] = b;
          body_sum  = body_sum + b;
          body_seen = body_seen + 1'b1;
        end else begin
          // A zero-length frame swallows its checksum byte and replays nothing.
          if (body_len != 0 && b == body_sum) begin
            for (i = 0; i < body_len; i++) begin
              body_q.push_back('{body_byte: body_mem[i], body_index: i[LEN_W-1:0],
                                 is_last: (i == body_len - 1)});
            end
          end
          phase = PH_HUNT_FIRST;
        end
      end
    endcase
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    body_beat_t want;
    if (!rst_n) begin
      first_sync  = SYNC_FIRST_RST;
      second_sync = SYNC_SECOND_RST;
      phase       = PH_HUNT_FIRST;
      body_len    = '0;
      body_seen   = '0;
      body_sum    = '0;
      body_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SYNC_FIRST) first_sync = cfg_wdata;
        else if (cfg_index == CFG_SYNC_SECOND) second_sync = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (body_q.size() == 0) begin
          report("body byte with none expected", out_tdata[7:0], -1);
        end else begin
          want = body_q.pop_front();
          if (out_tdata[7:0] != want.body_byte)
            report("body_byte", out_tdata[7:0], want.body_byte);
          if (out_tdata[13:8] != want.body_index)
            report("body_index", out_tdata[13:8], want.body_index);
          if (out_tlast != want.is_last)
            report("last", out_tlast, want.is_last);
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata);
    end
    pending = body_q.size();
  end

endmodule

@@ tb/sync_length_sum_frame_deframer_tb.sv @@
// Stimulus and verdict for the sync/length/checksum frame deframer.
`timescale 1ns / 1ps
module sync_length_sum_frame_deframer_tb;
  import sldf_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 60;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;
  logic                 out_tlast;
  int                   mismatches;
  int                   pending;

  bit                   calm = 1'b0;
  int                   bytes_sent = 0;
  logic [BYTE_W-1:0]    cur_first = SYNC_FIRST_RST;
  logic [BYTE_W-1:0]    cur_second = SYNC_SECOND_RST;

  // Opening bytes at the reset sync values.
  logic [7:0] opening [25] = '{
    8'hAA, 8'hAA, 8'h55, 8'h01, 8'hFF, 8'hFF,  // repeated first sync, one-byte body
    8'hAA, 8'h55, 8'h3D,                       // length one above the limit
    8'hAA, 8'h55, 8'h00, 8'h07,                // zero length eats the checksum
    8'hAA, 8'h55, 8'h02, 8'h00, 8'h01, 8'h05,  // checksum mismatch
    8'hAA, 8'h55, 8'h02, 8'h80, 8'h7F, 8'hFF   // good frame
  };

  sync_length_sum_frame_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sldf_frame_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Body consumer: stalls in short bursts until the calm stretch at the end.
  initial begin : body_sink
    int stall;
    stall = 0;
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      out_tready <= (stall == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Holds input off until every queued body byte is out and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= second;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_first  = first;
    cur_second = second;
  endtask

  task automatic send_frame(input int len, input bit sum_ok, input int extra_first);
    logic [7:0] sum;
    logic [7:0] b;
    int k;
    sum = '0;
    repeat (extra_first + 1) send_byte(cur_first);
    send_byte(cur_second);
    send_byte(len[7:0]);
    for (k = 0; k < len; k++) begin
      b = $urandom_range(0, 255);
      sum = sum + b;
      send_byte(b);
    end
    if (sum_ok) send_byte(sum);
    else send_byte(sum ^ 8'($urandom_range(1, 255)));
  endtask

  // Mostly short bodies, now and then an empty or a long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(11, 60);
    if (r == 1) return 0;
    return $urandom_range(1, 10);
  endfunction

  task automatic random_chunk();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_frame(pick_len(), 1'b1, 0);
    end else if (r < 70) begin
      send_frame(pick_len(), 1'b0, 0);
    end else if (r < 76) begin
      send_frame(pick_len(), 1'b1, $urandom_range(1, 3));
    end else if (r < 83) begin
      send_byte(cur_first);
      send_byte(cur_second);
      send_byte(8'($urandom_range(61, 255)));
    end else if (r < 89) begin
      send_byte(cur_first);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                           input bit longest);
    int start;
    settle();
    write_sync(first, second);
    start = bytes_sent;
    if (longest) send_frame(60, 1'b1, 0);
    while (bytes_sent - start < PHASE_BYTES) random_chunk();
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);

    run_phase(8'h00, 8'hFF, 1'b0);
    run_phase(8'hFF, 8'h00, 1'b0);
    // Equal sync values: the second byte of the pair must still advance to the length.
    run_phase(8'h3C, 8'h3C, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    calm = 1'b1;
    run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, 1'b1);
    settle();

    if (mismatches == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
